// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the parser modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- design/shpp_pkg.sv -----
// ----------------------------------------------------------------------------
// shpp_pkg
// Types and constants of the sensor-hub packet parser.
// ----------------------------------------------------------------------------
package shpp_pkg;

    localparam int LEN_W       = 15;
    localparam int WALK_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 15'd320;
    localparam logic [LEN_W-1:0]  HDR_LEN       = 15'd4;
    localparam logic [7:0]        CHAN_EXEC     = 8'd1;
    localparam logic [7:0]        CHAN_INPUT    = 8'd3;
    localparam logic [7:0]        ID_TS_BASE    = 8'hFB;
    localparam logic [7:0]        ID_TS_REBASE  = 8'hFA;
    localparam logic [7:0]        ID_ROTVEC     = 8'h08;
    localparam logic [7:0]        RESET_DONE_ID = 8'h01;
    localparam logic [WALK_W-1:0] TS_LEN        = 16'd5;
    localparam logic [WALK_W-1:0] ROT_LEN       = 16'd12;
    localparam logic [3:0]        ROT_FIRST_OFF = 4'd4;
    localparam logic [3:0]        ROT_LAST_OFF  = 4'd10;
    localparam logic [3:0]        ROT_END_OFF   = 4'd11;

    localparam logic EVT_ROTATION   = 1'b0;
    localparam logic EVT_RESET_DONE = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_INPUT = 2'd2
    } cmd_kind_t;

    typedef enum logic [3:0] {
        RT_NONE = 4'b0001,
        RT_SKIP = 4'b0010,
        RT_ROT  = 4'b0100,
        RT_STOP = 4'b1000
    } report_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] payload_len;
        logic [7:0]       data;
    } cmd_t;

endpackage

// ----- design/shpp_ifs.sv -----
// ----------------------------------------------------------------------------
// shpp_ifs
// Channel interfaces: byte stream in, parsed events out.
// ----------------------------------------------------------------------------
interface shpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_start;

    modport source (output valid, output data_byte, output packet_start, input ready);
    modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface shpp_event_if;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;

    modport source (output valid, output event_kind, output quat_i, output quat_j,
                    output quat_k, output quat_real, input ready);
    modport sink   (input valid, input event_kind, input quat_i, input quat_j,
                    input quat_k, input quat_real, output ready);
endinterface

// ----- design/shpp_front.sv -----
// ----------------------------------------------------------------------------
// shpp_front
// Header tracker: follows byte position, length and channel, drops bad or
// foreign bytes and issues walker commands for header byte 3 and payload.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shpp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [shpp_pkg::LEN_W-1:0] cfg_wdata,
    shpp_byte_if.sink                 byte_in,
    output logic                      cmd_valid,
    output shpp_pkg::cmd_t            cmd,
    input  logic                      cmd_ready
);
    import shpp_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] pos_reg,  pos_next;
    logic [LEN_W-1:0] len_reg,  len_next;
    logic [7:0]       chan_reg, chan_next;
    logic             ign_reg,  ign_next;

    logic             accept;
    logic [LEN_W-1:0] pos_cur;
    logic             ign_cur;
    logic [LEN_W-1:0] len_hdr;
    logic [LEN_W:0]   pos_plus;

    assign byte_in.ready = cmd_ready;
    assign accept        = byte_in.valid && cmd_ready;
    assign pos_cur       = byte_in.packet_start ? '0 : pos_reg;
    assign ign_cur       = byte_in.packet_start ? 1'b0 : ign_reg;
    assign len_hdr       = {byte_in.data_byte[6:0], len_reg[7:0]};
    assign pos_plus      = {1'b0, pos_cur} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        pos_next        = pos_reg;
        len_next        = len_reg;
        chan_next       = chan_reg;
        ign_next        = ign_reg;
        cmd_valid       = 1'b0;
        cmd.kind        = CMD_CLEAR;
        cmd.offset      = pos_cur - HDR_LEN;
        cmd.payload_len = len_reg - HDR_LEN;
        cmd.data        = byte_in.data_byte;
        if (accept && !ign_cur)
        begin
            ign_next = 1'b0;
            if (pos_cur == 15'd0)
            begin
                len_next = {7'd0, byte_in.data_byte};
            end
            else if (pos_cur == 15'd1)
            begin
                len_next = len_hdr;
                if (len_hdr == '0 || len_hdr > max_len_reg)
                begin
                    ign_next = 1'b1;
                end
            end
            else if (pos_cur == 15'd2)
            begin
                chan_next = byte_in.data_byte;
            end
            else if (pos_cur == 15'd3)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = CMD_CLEAR;
            end
            else if (chan_reg == CHAN_EXEC)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = CMD_EXEC;
            end
            else if (chan_reg == CHAN_INPUT)
            begin
                cmd_valid = 1'b1;
                cmd.kind  = CMD_INPUT;
            end
            pos_next = pos_plus[LEN_W-1:0];
            if (pos_cur >= 15'd3 && pos_plus >= {1'b0, len_reg})
            begin
                ign_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            pos_reg     <= '0;
            len_reg     <= '0;
            chan_reg    <= '0;
            ign_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            chan_reg <= chan_next;
            ign_reg  <= ign_next;
        end
    end

    `ASSERT_IMPLIES(a_front_no_cmd_without_accept, clk, rst_n, cmd_valid, accept)
endmodule

// ----- design/shpp_queue.sv -----
// ----------------------------------------------------------------------------
// shpp_queue
// Short command queue between header tracker and report walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shpp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  shpp_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output shpp_pkg::cmd_t pop_cmd,
    input  logic           pop_ready
);
    import shpp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLIES(a_queue_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `ASSERT_IMPLIES(a_queue_no_overflow, clk, rst_n, push_valid, push_ready)
endmodule

// ----- design/shpp_walker.sv -----
// ----------------------------------------------------------------------------
// shpp_walker
// Report walker: executes queued commands, assembles rotation vectors and
// holds each event in an output register until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shpp_walker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  shpp_pkg::cmd_t cmd,
    output logic           cmd_ready,
    shpp_event_if.source   event_out
);
    import shpp_pkg::*;

    logic [WALK_W-1:0] rs_reg,      rs_next;
    report_t           rt_reg,      rt_next;
    logic [55:0]       partial_reg, partial_next;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg,    kind_next;
    logic [15:0]       qi_reg, qj_reg, qk_reg, qr_reg;
    logic [15:0]       qi_next, qj_next, qk_next, qr_next;

    logic              advance;
    logic              pop;
    logic [WALK_W-1:0] p16;
    logic [WALK_W-1:0] p_end;
    logic [WALK_W-1:0] diff;
    logic [3:0]        off;
    logic [2:0]        lane;
    logic              reset_done_out;
    logic [15:0]       quat_any;

    assign advance   = !out_valid_reg || event_out.ready;
    assign cmd_ready = advance;
    assign pop       = cmd_valid && advance;
    assign p16       = {1'b0, cmd.offset};
    assign p_end     = p16 + ROT_LEN;
    assign diff      = p_end - rs_reg;
    assign off       = diff[3:0];
    assign lane      = 3'(off - ROT_FIRST_OFF);

    always_comb
    begin
        rs_next        = rs_reg;
        rt_next        = rt_reg;
        partial_next   = partial_reg;
        out_valid_next = advance ? 1'b0 : out_valid_reg;
        kind_next      = kind_reg;
        qi_next        = qi_reg;
        qj_next        = qj_reg;
        qk_next        = qk_reg;
        qr_next        = qr_reg;
        if (pop)
        begin
            case (cmd.kind)
                CMD_CLEAR:
                begin
                    rs_next      = '0;
                    rt_next      = RT_NONE;
                    partial_next = '0;
                end
                CMD_EXEC:
                begin
                    if (cmd.offset == '0 && cmd.data == RESET_DONE_ID)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = EVT_RESET_DONE;
                        qi_next        = '0;
                        qj_next        = '0;
                        qk_next        = '0;
                        qr_next        = '0;
                    end
                end
                CMD_INPUT:
                begin
                    if (rt_reg != RT_STOP)
                    begin
                        if (p16 == rs_reg)
                        begin
                            if (cmd.data == ID_TS_BASE || cmd.data == ID_TS_REBASE)
                            begin
                                rt_next = RT_SKIP;
                                rs_next = p16 + TS_LEN;
                            end
                            else if (cmd.data == ID_ROTVEC &&
                                     p_end <= {1'b0, cmd.payload_len})
                            begin
                                rt_next      = RT_ROT;
                                rs_next      = p_end;
                                partial_next = '0;
                            end
                            else
                            begin
                                rt_next = RT_STOP;
                            end
                        end
                        else if (rt_reg == RT_ROT && p16 < rs_reg && p_end >= rs_reg)
                        begin
                            if (off >= ROT_FIRST_OFF && off <= ROT_LAST_OFF)
                            begin
                                partial_next[{lane, 3'b000} +: 8] = cmd.data;
                            end
                            else if (off == ROT_END_OFF)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = EVT_ROTATION;
                                qi_next        = partial_reg[15:0];
                                qj_next        = partial_reg[31:16];
                                qk_next        = partial_reg[47:32];
                                qr_next        = {cmd.data, partial_reg[55:48]};
                            end
                        end
                    end
                end
                default:
                begin
                    rt_next = rt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg        <= '0;
            rt_reg        <= RT_NONE;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rs_reg        <= rs_next;
            rt_reg        <= rt_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        qi_reg   <= qi_next;
        qj_reg   <= qj_next;
        qk_reg   <= qk_next;
        qr_reg   <= qr_next;
    end

    assign event_out.valid      = out_valid_reg;
    assign event_out.event_kind = kind_reg;
    assign event_out.quat_i     = qi_reg;
    assign event_out.quat_j     = qj_reg;
    assign event_out.quat_k     = qk_reg;
    assign event_out.quat_real  = qr_reg;

    assign reset_done_out = out_valid_reg && kind_reg == EVT_RESET_DONE;
    assign quat_any       = qi_reg | qj_reg | qk_reg | qr_reg;

    `ASSERT_NEXT(a_walk_event_needs_pop, clk, rst_n, !out_valid_reg && !pop, !out_valid_reg)
    `ASSERT_IMPLIES(a_walk_reset_done_zero, clk, rst_n, reset_done_out, quat_any == '0)
endmodule

// ----- design/sensor_hub_packet_parser.sv -----
// ----------------------------------------------------------------------------
// sensor_hub_packet_parser
// Sensor-hub packet parser: reset-complete and rotation-vector events.
//
//   channel    dir  handshake      payload
//   byte_in    in   valid/ready    data_byte[7:0], packet_start
//   event_out  out  valid/ready    event_kind, quat_i/j/k/real[15:0] (Q1.14)
//   cfg        in   cfg_we         cfg_wdata[14:0] = max_packet_length
//
// One byte per cycle; the header tracker accepts a byte whenever the
// two-entry command queue has room.
// The walker executes one queued command per cycle unless its output stalls; an
// event goes valid after its completing byte passes the queue and the walker.
// Reset: max_packet_length is 320 and bytes are dropped until packet_start.
// A stalled output holds the walker; byte_in.ready drops once two commands wait.
// ----------------------------------------------------------------------------
module sensor_hub_packet_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [shpp_pkg::LEN_W-1:0] cfg_wdata,
    shpp_byte_if.sink                  byte_in,
    shpp_event_if.source               event_out
);
    import shpp_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    shpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .byte_in   (byte_in),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    shpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop_ready  (back_ready)
    );

    shpp_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .event_out (event_out)
    );
endmodule
